FILE: design/jgmm_pkg.sv
// jgmm_pkg: shared types, codes and helper functions for the joystick gear mode mapper
// no dependencies; used by every module of the block by scoped names
`timescale 1ns / 1ps

package jgmm_pkg;

	// mode codes
	localparam logic [2:0] MODE_NEUTRAL = 3'd0;
	localparam logic [2:0] MODE_GEAR1   = 3'd1;
	localparam logic [2:0] MODE_GEAR2   = 3'd2;
	localparam logic [2:0] MODE_GEAR3   = 3'd3;
	localparam logic [2:0] MODE_ADJ_A   = 3'd4;
	localparam logic [2:0] MODE_ADJ_B   = 3'd5;

	// configuration register indexes
	localparam logic [1:0] REG_STEP_LIMIT     = 2'd0;
	localparam logic [1:0] REG_LEVEL_MAX      = 2'd1;
	localparam logic [1:0] REG_HOLD_THRESHOLD = 2'd2;

	localparam logic [6:0] STEP_LIMIT_RST     = 7'd5;
	localparam logic [6:0] LEVEL_MAX_RST      = 7'd125;
	localparam logic [2:0] HOLD_THRESHOLD_RST = 3'd5;
	localparam logic [2:0] HOLD_COUNT_MAX     = 3'd7;

	localparam int IN_W  = 32;
	localparam int OUT_W = 72;

	localparam logic signed [10:0] NEUTRAL_DRIVE = 11'sd100;
	localparam logic signed [10:0] GEAR1_OFFSET  = 11'sd50;

	typedef struct packed {
		logic [6:0] step_limit;
		logic [6:0] level_max;
		logic [2:0] hold_threshold;
	} cfg_t;

	// declared msb first so the first field lands in the lowest bits
	typedef struct packed {
		logic              pad;
		logic              reset_key_b;
		logic              reset_key_a;
		logic              adjust_b_key;
		logic              adjust_a_key;
		logic              gear3_key;
		logic              gear2_key;
		logic              gear1_key;
		logic signed [7:0] stick_right_y;
		logic signed [7:0] stick_left_y;
		logic signed [7:0] stick_left_x;
	} in_item_t;

	typedef struct packed {
		logic [6:0]         pad;
		logic               reset_event;
		logic [6:0]         level_b1;
		logic [6:0]         level_a1;
		logic [6:0]         level_b0;
		logic [6:0]         level_a0;
		logic signed [7:0]  left_y_out;
		logic signed [10:0] drive_y;
		logic signed [10:0] drive_x;
		logic [2:0]         mode_before;
		logic [2:0]         mode_now;
	} out_item_t;

	// symmetric clamp of a stick value to +/-lim
	function automatic logic signed [7:0] clamp_step(logic signed [7:0] v, logic [6:0] lim);
		logic signed [8:0] v9;
		logic signed [8:0] p;
		logic signed [8:0] n;
		logic signed [7:0] r;
		v9 = {v[7], v};
		p  = {2'b00, lim};
		n  = -p;
		if (v9 <= n) begin
			r = n[7:0];
		end else if (v9 >= p) begin
			r = p[7:0];
		end else begin
			r = v;
		end
		return r;
	endfunction

	// add a clamped step to a level, saturating at 0 and lmax
	function automatic logic [6:0] level_add(logic [6:0] lvl, logic signed [7:0] d,
			logic [6:0] lmax);
		logic signed [9:0] sum;
		logic signed [9:0] mx;
		logic [6:0]        r;
		sum = signed'({3'b000, lvl}) + signed'({{2{d[7]}}, d});
		mx  = {3'b000, lmax};
		if (sum <= 10'sd0) begin
			r = 7'd0;
		end else if (sum >= mx) begin
			r = lmax;
		end else begin
			r = sum[6:0];
		end
		return r;
	endfunction

endpackage

FILE: design/jgmm_cfg.sv
// jgmm_cfg: configuration registers written through the plain write port
// depends on jgmm_pkg
`timescale 1ns / 1ps

module jgmm_cfg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [6:0]    cfg_data,
	output jgmm_pkg::cfg_t cfg
);

	jgmm_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_limit     <= jgmm_pkg::STEP_LIMIT_RST;
			cfg_q.level_max      <= jgmm_pkg::LEVEL_MAX_RST;
			cfg_q.hold_threshold <= jgmm_pkg::HOLD_THRESHOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				jgmm_pkg::REG_STEP_LIMIT:     cfg_q.step_limit     <= cfg_data;
				jgmm_pkg::REG_LEVEL_MAX:      cfg_q.level_max      <= cfg_data;
				jgmm_pkg::REG_HOLD_THRESHOLD: cfg_q.hold_threshold <= cfg_data[2:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: design/jgmm_core.sv
// jgmm_core: mode selection, drive scaling, hold counter and auxiliary levels
// depends on jgmm_pkg; state advances once per item moved to the result register
`timescale 1ns / 1ps

module jgmm_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  jgmm_pkg::in_item_t  item,
	input  jgmm_pkg::cfg_t      cfg,
	output jgmm_pkg::out_item_t result
);

	logic [2:0] mode_q;
	logic [2:0] hold_q;
	logic [6:0] lvl_q [4];

	logic              chord;
	logic              adj_a;
	logic              adj_b;
	logic [2:0]        hold_inc;
	logic              fired;
	logic [2:0]        hold_nxt;
	logic [6:0]        base [4];
	logic [6:0]        lvl_nxt [4];
	logic signed [7:0] ly_c;
	logic signed [7:0] ry_c;
	logic [6:0]        sum_lo;
	logic [6:0]        sum_hi;
	logic signed [10:0] x11;
	logic signed [10:0] ry11;
	logic signed [10:0] xp;
	logic signed [10:0] half;
	logic [2:0]        mode;
	logic signed [10:0] dx;
	logic signed [10:0] dy;
	logic signed [7:0] oly;

	assign chord = !item.reset_key_a && !item.reset_key_b;
	assign adj_a = !item.adjust_a_key;
	assign adj_b = !item.adjust_b_key;

	// count saturates at seven, so a threshold of seven never fires
	assign hold_inc = (hold_q < jgmm_pkg::HOLD_COUNT_MAX) ? hold_q + 3'd1 : hold_q;
	assign fired    = chord && (hold_inc > cfg.hold_threshold);
	assign hold_nxt = (chord && !fired) ? hold_inc : 3'd0;

	assign ly_c = jgmm_pkg::clamp_step(item.stick_left_y, cfg.step_limit);
	assign ry_c = jgmm_pkg::clamp_step(item.stick_right_y, cfg.step_limit);

	assign x11  = {{3{item.stick_left_x[7]}}, item.stick_left_x};
	assign ry11 = {{3{item.stick_right_y[7]}}, item.stick_right_y};
	assign xp   = x11 + jgmm_pkg::NEUTRAL_DRIVE;
	// halve rounding toward zero
	assign half = (xp + signed'({10'd0, xp[10]})) >>> 1;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			base[k] = fired ? 7'd0 : lvl_q[k];
		end
		lvl_nxt = base;
		sum_lo  = 7'd0;
		sum_hi  = 7'd0;
		oly     = item.stick_left_y;
		if (adj_a || adj_b) begin
			sum_lo = jgmm_pkg::level_add(adj_a ? base[0] : base[1], ly_c, cfg.level_max);
			sum_hi = jgmm_pkg::level_add(adj_a ? base[2] : base[3], ry_c, cfg.level_max);
			if (adj_a) begin
				lvl_nxt[0] = sum_lo;
				lvl_nxt[2] = sum_hi;
			end else begin
				lvl_nxt[1] = sum_lo;
				lvl_nxt[3] = sum_hi;
			end
			dx   = x11;
			dy   = {{3{ry_c[7]}}, ry_c};
			oly  = ly_c;
			mode = adj_a ? jgmm_pkg::MODE_ADJ_A : jgmm_pkg::MODE_ADJ_B;
		end else if (item.gear1_key) begin
			dx   = half + jgmm_pkg::GEAR1_OFFSET;
			dy   = ry11 + jgmm_pkg::NEUTRAL_DRIVE;
			mode = jgmm_pkg::MODE_GEAR1;
		end else if (item.gear2_key) begin
			dx   = xp;
			dy   = (ry11 <<< 1) + jgmm_pkg::NEUTRAL_DRIVE;
			mode = jgmm_pkg::MODE_GEAR2;
		end else if (item.gear3_key) begin
			dx   = (x11 <<< 1) + jgmm_pkg::NEUTRAL_DRIVE;
			dy   = (ry11 <<< 2) + jgmm_pkg::NEUTRAL_DRIVE;
			mode = jgmm_pkg::MODE_GEAR3;
		end else begin
			dx   = jgmm_pkg::NEUTRAL_DRIVE;
			dy   = jgmm_pkg::NEUTRAL_DRIVE;
			mode = jgmm_pkg::MODE_NEUTRAL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= jgmm_pkg::MODE_NEUTRAL;
			hold_q <= 3'd0;
			for (int k = 0; k < 4; k++) begin
				lvl_q[k] <= 7'd0;
			end
		end else if (adv) begin
			mode_q <= mode;
			hold_q <= hold_nxt;
			lvl_q  <= lvl_nxt;
		end
	end

	always_comb begin
		result             = '0;
		result.mode_now    = mode;
		result.mode_before = mode_q;
		result.drive_x     = dx;
		result.drive_y     = dy;
		result.left_y_out  = oly;
		result.level_a0    = lvl_nxt[0];
		result.level_b0    = lvl_nxt[1];
		result.level_a1    = lvl_nxt[2];
		result.level_b1    = lvl_nxt[3];
		result.reset_event = fired;
	end

endmodule

FILE: design/joystick_gear_mode_mapper.sv
// joystick_gear_mode_mapper: top level, input register, result register and handshake
// depends on jgmm_pkg, jgmm_cfg, jgmm_core
//
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  s_axis_tdata[31:0] one scan sample
//  m_axis    out        m_axis_tvalid/m_axis_tready  m_axis_tdata[71:0] one result
//  cfg       in         cfg_we (no wait)             cfg_index[1:0], cfg_data[6:0]
//
// one item per cycle sustained while m_axis_tready is high; result valid once registered
// the input register feeds the core logic, which updates state as its result is registered
// while the result register is stalled the input register still takes one more item
// reset clears all valid flags, the mode, the hold count and the four levels
`timescale 1ns / 1ps

module joystick_gear_mode_mapper (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// stick_left_x, stick_left_y, stick_right_y, gear1_key, gear2_key, gear3_key,
	// adjust_a_key, adjust_b_key, reset_key_a, reset_key_b, zero pad
	input  logic [31:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// mode_now, mode_before, drive_x, drive_y, left_y_out, level_a0, level_b0,
	// level_a1, level_b1, reset_event, zero pad
	output logic [71:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data
);

	jgmm_pkg::cfg_t      cfg;
	jgmm_pkg::in_item_t  item_s1;
	jgmm_pkg::out_item_t result;
	jgmm_pkg::out_item_t res_s2;
	logic                v_s1;
	logic                v_s2;
	logic                adv;
	logic                in_acc;

	assign adv           = v_s1 && (!v_s2 || m_axis_tready);
	assign s_axis_tready = !v_s1 || adv;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	jgmm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	jgmm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_acc) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				v_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1 <= jgmm_pkg::in_item_t'(s_axis_tdata);
		end
		if (adv) begin
			res_s2 <= result;
		end
	end

	assign m_axis_tvalid = v_s2;
	assign m_axis_tdata  = res_s2;

endmodule

FILE: design/jgmm_checker.sv
// jgmm_checker: port-level checks on the result stream, bound to the top level
// depends on jgmm_pkg and joystick_gear_mode_mapper
`timescale 1ns / 1ps

module jgmm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [31:0] s_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [71:0] m_axis_tdata,
	input logic        cfg_we,
	input logic [1:0]  cfg_index,
	input logic [6:0]  cfg_data
);

	jgmm_pkg::out_item_t res;
	logic [2:0]          last_mode_q;
	logic                unused;

	assign res    = m_axis_tdata;
	assign unused = s_axis_tvalid ^ s_axis_tready ^ (^s_axis_tdata) ^ cfg_we
		^ (^cfg_index) ^ (^cfg_data);

	// mode of the last delivered item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_mode_q <= jgmm_pkg::MODE_NEUTRAL;
		end else if (m_axis_tvalid && m_axis_tready) begin
			last_mode_q <= res.mode_now;
		end
	end

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result valid dropped while stalled");

	a_data_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_mode_chain: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> res.mode_before == last_mode_q)
		else $error("mode_before does not match previous mode_now");

	a_neutral: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.mode_now == jgmm_pkg::MODE_NEUTRAL && !unused |->
			res.drive_x == jgmm_pkg::NEUTRAL_DRIVE && res.drive_y == jgmm_pkg::NEUTRAL_DRIVE)
		else $error("neutral mode without neutral drive");

	a_neutral_b: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.mode_now == jgmm_pkg::MODE_NEUTRAL && unused |->
			res.drive_x == jgmm_pkg::NEUTRAL_DRIVE && res.drive_y == jgmm_pkg::NEUTRAL_DRIVE)
		else $error("neutral mode without neutral drive");

endmodule

bind joystick_gear_mode_mapper jgmm_checker u_jgmm_checker (.*);

FILE: tb/tb_joystick_gear_mode_mapper.sv
// tb_joystick_gear_mode_mapper: self-checking testbench for the joystick gear mode mapper
// depends on jgmm_pkg and joystick_gear_mode_mapper; a scoreboard class predicts every result
`timescale 1ns / 1ps

module tb_joystick_gear_mode_mapper;
	import jgmm_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS    = 110;

	class mapper_scoreboard;
		int step_lim;
		int lvl_max;
		int hold_thr;
		int hold_cnt;
		int levels[4];
		logic [2:0] last_mode;
		out_item_t pending[$];
		int mismatches;

		function new();
			step_lim   = STEP_LIMIT_RST;
			lvl_max    = LEVEL_MAX_RST;
			hold_thr   = HOLD_THRESHOLD_RST;
			hold_cnt   = 0;
			levels     = '{0, 0, 0, 0};
			last_mode  = MODE_NEUTRAL;
			mismatches = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [6:0] val);
			case (idx)
				REG_STEP_LIMIT: begin
					step_lim = val;
				end
				REG_LEVEL_MAX: begin
					lvl_max = val;
				end
				REG_HOLD_THRESHOLD: begin
					hold_thr = val[2:0];
				end
				default: begin
				end
			endcase
		endfunction

		function int clip(int v, int lo, int hi);
			if (v <= lo) begin
				return lo;
			end
			if (v >= hi) begin
				return hi;
			end
			return v;
		endfunction

		// work out the result of one accepted sample and queue it
		function void note_sample(in_item_t it);
			int x;
			int ly;
			int ry;
			int lo;
			int dx;
			int dy;
			bit fired;
			logic [2:0] mode;
			out_item_t r;
			x = $signed(it.stick_left_x);
			ly = $signed(it.stick_left_y);
			ry = $signed(it.stick_right_y);
			fired = 1'b0;
			if (!it.reset_key_a && !it.reset_key_b) begin
				if (hold_cnt < HOLD_COUNT_MAX) begin
					hold_cnt++;
				end
				if (hold_cnt > hold_thr) begin
					levels = '{0, 0, 0, 0};
					hold_cnt = 0;
					fired = 1'b1;
				end
			end else begin
				hold_cnt = 0;
			end
			if (!it.adjust_a_key || !it.adjust_b_key) begin
				// adjust a pressed picks levels 0 and 2, else b picks 1 and 3
				lo = it.adjust_a_key ? 1 : 0;
				ly = clip(ly, -step_lim, step_lim);
				ry = clip(ry, -step_lim, step_lim);
				levels[lo] = clip(levels[lo] + ly, 0, lvl_max);
				levels[lo + 2] = clip(levels[lo + 2] + ry, 0, lvl_max);
				dx = x;
				dy = ry;
				mode = it.adjust_a_key ? MODE_ADJ_B : MODE_ADJ_A;
			end else if (it.gear1_key) begin
				dx = (x + 100) / 2 + 50;
				dy = ry + 100;
				mode = MODE_GEAR1;
			end else if (it.gear2_key) begin
				dx = x + 100;
				dy = ry * 2 + 100;
				mode = MODE_GEAR2;
			end else if (it.gear3_key) begin
				dx = x * 2 + 100;
				dy = ry * 4 + 100;
				mode = MODE_GEAR3;
			end else begin
				dx = 100;
				dy = 100;
				mode = MODE_NEUTRAL;
			end
			r = '0;
			r.mode_now = mode;
			r.mode_before = last_mode;
			r.drive_x = dx[10:0];
			r.drive_y = dy[10:0];
			r.left_y_out = ly[7:0];
			r.level_a0 = levels[0][6:0];
			r.level_b0 = levels[1][6:0];
			r.level_a1 = levels[2][6:0];
			r.level_b1 = levels[3][6:0];
			r.reset_event = fired;
			last_mode = mode;
			pending.push_back(r);
		endfunction

		function void cmp(string field, int e, int a);
			if (e != a) begin
				$display("%0t: %s expected %0d actual %0d", $time, field, e, a);
				mismatches++;
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t e;
			if (pending.size() == 0) begin
				$display("%0t: result with no sample pending, actual %h", $time, got);
				mismatches++;
				return;
			end
			e = pending.pop_front();
			cmp("mode_now", e.mode_now, got.mode_now);
			cmp("mode_before", e.mode_before, got.mode_before);
			cmp("drive_x", $signed(e.drive_x), $signed(got.drive_x));
			cmp("drive_y", $signed(e.drive_y), $signed(got.drive_y));
			cmp("left_y_out", $signed(e.left_y_out), $signed(got.left_y_out));
			cmp("level_a0", e.level_a0, got.level_a0);
			cmp("level_b0", e.level_b0, got.level_b0);
			cmp("level_a1", e.level_a1, got.level_a1);
			cmp("level_b1", e.level_b1, got.level_b1);
			cmp("reset_event", e.reset_event, got.reset_event);
			cmp("pad", e.pad, got.pad);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [6:0]  cfg_data;

	mapper_scoreboard sb = new();

	int quiet_cycles = 0;
	int burst_left = 0;
	int chord_left = 0;
	bit drift = 1'b1;
	int rdy_style = 0;
	int rdy_window = 0;

	joystick_gear_mode_mapper i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// monitor both channels and guard against a hang
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			sb.note_sample(in_item_t'(s_axis_tdata));
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			sb.check_result(out_item_t'(m_axis_tdata));
		end
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_joystick_gear_mode_mapper: FAIL");
			$finish;
		end
	end

	// receiver back-pressure: the style is redrawn at random whenever its window runs out
	always @(posedge clk) begin
		if (rdy_window == 0) begin
			rdy_style <= $urandom_range(0, 3);
			rdy_window <= $urandom_range(20, 80);
		end else begin
			rdy_window <= rdy_window - 1;
		end
		case (rdy_style)
			0: begin
				m_axis_tready <= 1'b1;
			end
			1: begin
				m_axis_tready <= 1'($urandom_range(0, 1));
			end
			2: begin
				m_axis_tready <= ($urandom_range(0, 3) != 0);
			end
			default: begin
				m_axis_tready <= ($urandom_range(0, 7) == 0);
			end
		endcase
	end

	function automatic in_item_t mk(int x, int ly, int ry, bit [2:0] gears, bit [1:0] adj,
			bit [1:0] rst);
		in_item_t it;
		it = '0;
		it.stick_left_x = x[7:0];
		it.stick_left_y = ly[7:0];
		it.stick_right_y = ry[7:0];
		it.gear1_key = gears[0];
		it.gear2_key = gears[1];
		it.gear3_key = gears[2];
		it.adjust_a_key = adj[0];
		it.adjust_b_key = adj[1];
		it.reset_key_a = rst[0];
		it.reset_key_b = rst[1];
		return it;
	endfunction

	// extremes, zero, raw bits or a value leaning the current drift way
	function automatic int rand_axis();
		int v;
		case ($urandom_range(0, 7))
			0: v = -128;
			1: v = 127;
			2: v = 0;
			3, 4, 5: v = $signed(8'($urandom));
			default: v = drift ? $urandom_range(0, 127) : -$urandom_range(1, 128);
		endcase
		return v;
	endfunction

	// chord runs of random length so the hold counter crosses every threshold
	function automatic in_item_t rand_sample();
		in_item_t it;
		bit [1:0] rst;
		if ($urandom_range(0, 39) == 0) begin
			drift = !drift;
		end
		if (chord_left == 0 && $urandom_range(0, 11) == 0) begin
			chord_left = $urandom_range(1, 9);
		end
		if (chord_left > 0) begin
			rst = 2'b00;
			chord_left--;
		end else begin
			rst = 2'($urandom);
		end
		it = mk(rand_axis(), rand_axis(), rand_axis(), 3'($urandom),
			{$urandom_range(0, 2) != 0, $urandom_range(0, 2) != 0}, rst);
		return it;
	endfunction

	task automatic push_sample(in_item_t it);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= it;
		do @(posedge clk); while (!s_axis_tready);
		if (burst_left > 0) begin
			burst_left--;
		end
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic wait_idle();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [6:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic set_config(int step, int lmax, int hold);
		write_reg(REG_STEP_LIMIT, step[6:0]);
		write_reg(REG_LEVEL_MAX, lmax[6:0]);
		write_reg(REG_HOLD_THRESHOLD, hold[6:0]);
		cfg_we <= 1'b0;
	endtask

	task automatic run_random(int n);
		repeat (n) push_sample(rand_sample());
		s_axis_tvalid <= 1'b0;
		wait_idle();
	endtask

	initial begin
		in_item_t directed[$];
		int settings[7][3];
		settings = '{'{127, 127, 0}, '{127, 127, 7}, '{3, 20, 6}, '{0, 0, 1},
			'{0, 127, 2}, '{5, 125, 5}, '{1, 127, 3}};
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_STEP_LIMIT;
		cfg_data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// modes, priorities, field extremes and truncation of the gear one halving
		directed.push_back(mk(0, 0, 0, 3'b000, 2'b11, 2'b11));
		directed.push_back(mk(127, 127, 127, 3'b001, 2'b11, 2'b11));
		directed.push_back(mk(-128, -128, -128, 3'b001, 2'b11, 2'b11));
		directed.push_back(mk(-101, 5, -1, 3'b001, 2'b11, 2'b11));
		directed.push_back(mk(-128, 0, 127, 3'b010, 2'b11, 2'b11));
		directed.push_back(mk(127, -128, -128, 3'b100, 2'b11, 2'b11));
		directed.push_back(mk(-128, 127, 127, 3'b100, 2'b11, 2'b11));
		directed.push_back(mk(17, 3, -9, 3'b111, 2'b11, 2'b11));
		directed.push_back(mk(-5, -6, 64, 3'b110, 2'b11, 2'b11));
		directed.push_back(mk(127, 127, 127, 3'b000, 2'b10, 2'b11));
		directed.push_back(mk(-128, -128, -128, 3'b111, 2'b01, 2'b11));
		directed.push_back(mk(9, 3, -2, 3'b000, 2'b00, 2'b11));
		// chord held long enough to clear, last sample also adjusting
		repeat (5) directed.push_back(mk(0, 0, 0, 3'b000, 2'b11, 2'b00));
		directed.push_back(mk(1, 127, 127, 3'b000, 2'b01, 2'b00));
		// chord released part-way restarts the count
		directed.push_back(mk(0, 0, 0, 3'b010, 2'b11, 2'b00));
		directed.push_back(mk(0, 0, 0, 3'b010, 2'b11, 2'b01));
		directed.push_back(mk(0, 0, 0, 3'b000, 2'b11, 2'b10));
		directed.push_back(mk(0, 0, 0, 3'b100, 2'b11, 2'b00));
		directed.push_back(mk(-1, -1, -1, 3'b111, 2'b11, 2'b11));
		foreach (directed[i]) begin
			push_sample(directed[i]);
		end
		s_axis_tvalid <= 1'b0;
		wait_idle();

		run_random(PHASE_ITEMS);
		foreach (settings[i]) begin
			set_config(settings[i][0], settings[i][1], settings[i][2]);
			run_random(PHASE_ITEMS);
		end
		set_config($urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 7));
		run_random(PHASE_ITEMS);

		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("tb_joystick_gear_mode_mapper: PASS");
		end else begin
			$display("tb_joystick_gear_mode_mapper: FAIL");
		end
		$finish;
	end

endmodule

FILE: filelist.f
design/jgmm_pkg.sv
design/jgmm_cfg.sv
design/jgmm_core.sv
design/joystick_gear_mode_mapper.sv
design/jgmm_checker.sv
tb/tb_joystick_gear_mode_mapper.sv
